// ===== rtl/btcg_pkg.sv =====
// Shared types and constants for the battery temperature charge guard.
// Used by every module of the block; depends on nothing else.
package btcg_pkg;

  // Health classes kept by the guard
  typedef enum logic [2:0] {
    H_UNKNOWN = 3'd0,
    H_COLD    = 3'd1,
    H_COOL    = 3'd2,
    H_GOOD    = 3'd3,
    H_WARM    = 3'd4,
    H_HOT     = 3'd5
  } health_t;

  // Charge-current limit codes
  typedef enum logic [2:0] {
    LIM_RELEASED    = 3'd0,
    LIM_BLOCKED     = 3'd1,
    LIM_COOL_ALERT  = 3'd2,
    LIM_COOL_NORMAL = 3'd3,
    LIM_WARM_CHARGE = 3'd4
  } ilim_t;

  // Polling-rate classes
  typedef enum logic [1:0] {
    POLL_UNKNOWN   = 2'd0,
    POLL_NORMAL    = 2'd1,
    POLL_WARNING   = 2'd2,
    POLL_EMERGENCY = 2'd3
  } poll_t;

  localparam int TEMP_W  = 12;
  localparam int MV_W    = 13;
  localparam int NUM_REGS = 8;
  localparam int CFG_IDX_W = 4;

  typedef logic signed [TEMP_W-1:0] thr_t;

  // Threshold register indexes
  localparam logic [CFG_IDX_W-1:0] REG_UP_COOL = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UP_GOOD = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UP_WARM = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UP_HOT  = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DN_WARM = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DN_GOOD = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DN_COOL = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DN_COLD = 4'd7;

  // Threshold reset values, tenths of a degree C, in register order
  localparam thr_t THR_RESET [NUM_REGS] = '{
    12'sd30, 12'sd120, 12'sd450, 12'sd550, 12'sd520, 12'sd430, 12'sd100, 12'sd0
  };

  // Classified item passed from front to back through the queue
  typedef struct packed {
    health_t          health;
    logic             awake;
    logic             updated;
    logic             charging;
    logic [MV_W-1:0]  mv;
  } cls_item_t;

  // Finished result as driven on the output channel
  typedef struct packed {
    poll_t   poll;
    logic    awake;
    logic    float_lim;
    ilim_t   ilim;
    health_t health;
  } result_t;

  // Queue status seen by the back end
  typedef struct packed {
    logic      valid;
    cls_item_t item;
  } q_head_t;

endpackage

// ===== rtl/battery_temp_charge_guard.sv =====
// Battery temperature charge guard, top level. Uses btcg_pkg, btcg_front,
// btcg_fifo and btcg_back.
// The item is classified and written to the queue at the accept edge, then code
// mapped into the output register once that register is free to load.
// Throughput: 1 sample per cycle while the queue has room (in_tready high).
// Reset (rst_n low, synchronous): health unknown, awake clear, thresholds at
// their defaults, queue and output register empty. Config ready every cycle.
module battery_temp_charge_guard
  import btcg_pkg::*;
#(
  parameter int COOL_ALERT_MV = 4000,
  parameter int Q_DEPTH       = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // sample channel
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [31:0]          in_tdata,  // temp_decidegc[11:0], battery_mv[24:12],
                                          // is_charging[25], zero pad
  input  logic                 in_tuser,  // reading_valid
  // result channel
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [15:0]          out_tdata, // health_class[2:0], current_limit[5:3],
                                          // float_limited[6], stay_awake[7],
                                          // poll_class[9:8], zero pad
  output logic                 out_tuser, // updated
  // threshold write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TEMP_W-1:0]    cfg_data
);

  logic      q_full, push, pop;
  cls_item_t push_item;
  q_head_t   head;
  result_t   res;

  assign cfg_ready = 1'b1;

  btcg_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_tvalid),
    .q_full        (q_full),
    .reading_valid (in_tuser),
    .temp          (in_tdata[11:0]),
    .mv            (in_tdata[24:12]),
    .charging      (in_tdata[25]),
    .in_ready      (in_tready),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .push          (push),
    .push_item     (push_item)
  );

  btcg_fifo #(.DEPTH(Q_DEPTH)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .full      (q_full),
    .head      (head)
  );

  btcg_back #(.COOL_ALERT_MV(COOL_ALERT_MV)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_res     (res),
    .out_updated (out_tuser)
  );

  // Pack result fields, highest first
  assign out_tdata = {6'b0, res.poll, res.awake, res.float_lim, res.ilim, res.health};

endmodule

// ===== rtl/btcg_front.sv =====
// Front end: threshold registers, health state and hysteresis classification.
// Depends on btcg_pkg; pushes one classified item per accepted sample.
module btcg_front
  import btcg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // sample side
  input  logic                 in_valid,
  input  logic                 q_full,
  input  logic                 reading_valid,
  input  logic [TEMP_W-1:0]    temp,
  input  logic [MV_W-1:0]      mv,
  input  logic                 charging,
  output logic                 in_ready,
  // threshold writes
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TEMP_W-1:0]    cfg_data,
  // queue push
  output logic                 push,
  output cls_item_t            push_item
);

  thr_t    thr_r [NUM_REGS];
  health_t health_r, health_nxt;
  logic    awake_r, awake_nxt;

  health_t cur, h_new;
  thr_t    t_s, lo_cold, lo_cool, lo_warm, lo_hot;
  logic    awake_new;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;
  assign t_s      = $signed(temp);

  // Per-state bounds, then fixed-order compares
  always_comb begin
    cur     = (health_r > H_HOT) ? H_UNKNOWN : health_r;
    lo_cold = thr_r[REG_DN_COLD[2:0]];
    lo_cool = thr_r[REG_DN_COOL[2:0]];
    lo_warm = thr_r[REG_UP_WARM[2:0]];
    lo_hot  = thr_r[REG_UP_HOT[2:0]];
    case (cur)
      H_COLD:  lo_cold = thr_r[REG_UP_COOL[2:0]];
      H_COOL:  lo_cool = thr_r[REG_UP_GOOD[2:0]];
      H_WARM:  lo_warm = thr_r[REG_DN_GOOD[2:0]];
      H_HOT:   lo_hot  = thr_r[REG_DN_WARM[2:0]];
      default: ;
    endcase
    if (t_s < lo_cold)      h_new = H_COLD;
    else if (t_s < lo_cool) h_new = H_COOL;
    else if (t_s < lo_warm) h_new = H_GOOD;
    else if (t_s < lo_hot)  h_new = H_WARM;
    else                    h_new = H_HOT;
    awake_new = ((h_new != H_GOOD) && charging) || (h_new == H_HOT);
  end

  // State update and queued item
  always_comb begin
    health_nxt = health_r;
    awake_nxt  = awake_r;
    if (push && reading_valid) begin
      health_nxt = h_new;
      awake_nxt  = awake_new;
    end
    push_item.health   = reading_valid ? h_new : cur;
    push_item.awake    = reading_valid ? awake_new : awake_r;
    push_item.updated  = reading_valid;
    push_item.charging = charging;
    push_item.mv       = mv;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      health_r <= H_UNKNOWN;
      awake_r  <= 1'b0;
    end else begin
      health_r <= health_nxt;
      awake_r  <= awake_nxt;
    end
  end

  // Threshold registers; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        thr_r[i] <= THR_RESET[i];
      end
    end else if (cfg_we && (cfg_index < CFG_IDX_W'(NUM_REGS))) begin
      thr_r[cfg_index[2:0]] <= $signed(cfg_data);
    end
  end

endmodule

// ===== rtl/btcg_fifo.sv =====
// Short queue between classification front end and result back end.
// Depends on btcg_pkg for the item type.
module btcg_fifo
  import btcg_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  cls_item_t push_item,
  input  logic      pop,
  output logic      full,
  output q_head_t   head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cls_item_t        mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_pop;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign full       = (cnt_r == CNT_W'(DEPTH));
  assign head.valid = (cnt_r != '0);
  assign head.item  = mem_r[rd_ptr_r];
  assign do_pop     = pop && head.valid;

  // Pointer and count bookkeeping
  always_comb begin
    wr_ptr_nxt = push   ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !do_pop)      cnt_nxt = cnt_r + CNT_W'(1);
    else if (!push && do_pop) cnt_nxt = cnt_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== rtl/btcg_back.sv =====
// Back end: maps a classified item to limit, float, awake and poll codes
// and holds it in the output register. Depends on btcg_pkg.
module btcg_back
  import btcg_pkg::*;
#(
  parameter int COOL_ALERT_MV = 4000
) (
  input  logic    clk,
  input  logic    rst_n,
  input  q_head_t head,
  output logic    pop,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res,
  output logic    out_updated
);

  localparam logic [MV_W-1:0] ALERT_MV = MV_W'(COOL_ALERT_MV);

  logic    out_valid_r, out_valid_nxt;
  result_t res_r, res_nxt;
  logic    upd_r;
  logic    load;

  assign load = !out_valid_r || out_ready;
  assign pop  = load && head.valid;

  // Code mapping
  always_comb begin
    res_nxt.health    = head.item.health;
    res_nxt.awake     = head.item.awake;
    res_nxt.ilim      = LIM_RELEASED;
    res_nxt.float_lim = 1'b0;
    if (head.item.updated && head.item.charging) begin
      case (head.item.health)
        H_COOL:        res_nxt.ilim = (head.item.mv >= ALERT_MV) ? LIM_COOL_ALERT
                                                                 : LIM_COOL_NORMAL;
        H_WARM:        res_nxt.ilim = LIM_WARM_CHARGE;
        H_HOT, H_COLD: res_nxt.ilim = LIM_BLOCKED;
        default:       res_nxt.ilim = LIM_RELEASED;
      endcase
      res_nxt.float_lim = (head.item.health == H_WARM) || (head.item.health == H_HOT);
    end
    case (head.item.health)
      H_HOT, H_COLD:  res_nxt.poll = POLL_EMERGENCY;
      H_WARM, H_COOL: res_nxt.poll = POLL_WARNING;
      H_GOOD:         res_nxt.poll = POLL_NORMAL;
      default:        res_nxt.poll = POLL_UNKNOWN;
    endcase
    out_valid_nxt = load ? head.valid : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload, no reset needed
  always_ff @(posedge clk) begin
    if (pop) begin
      res_r <= res_nxt;
      upd_r <= head.item.updated;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_res     = res_r;
  assign out_updated = upd_r;

endmodule

// ===== rtl/btcg_checker.sv =====
// Port-level checker for the battery temperature charge guard, with bind.
// Depends on btcg_pkg for class and limit codes.
module btcg_checker
  import btcg_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tuser
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // Invalid samples release both limits
  a_no_upd_no_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[5:3] == LIM_RELEASED && !out_tdata[6])
    else $error("limit set on a non-updating sample");

  // Float limit only in warm or hot
  a_float_class: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[6] |-> out_tdata[2:0] == H_WARM || out_tdata[2:0] == H_HOT)
    else $error("float limit outside warm or hot");

  // Hot always asks to stay awake
  a_hot_awake: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2:0] == H_HOT |-> out_tdata[7])
    else $error("hot class without stay-awake");

  // Poll class is emergency in hot or cold
  a_poll_map: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[2:0] == H_HOT || out_tdata[2:0] == H_COLD)
    |-> out_tdata[9:8] == POLL_EMERGENCY)
    else $error("poll class does not match hot or cold");

endmodule

bind battery_temp_charge_guard btcg_checker u_btcg_checker (.*);
